FILE: rtl/core/gpbtc_pkg.sv
// ----------------------------------------------------------------------------
// gpbtc_pkg
// shared types and constants of the gate pair bee traffic counter
// ----------------------------------------------------------------------------
package gpbtc_pkg;

  localparam int NOW_W   = 32;   // sample timestamp width
  localparam int WORD_W  = 48;   // sensor word width
  localparam int CFG_W   = 16;   // configuration register width
  localparam int CNT_W   = 16;   // net count width
  localparam int DWELL_W = 16;   // dwell width
  localparam int TALLY_W = 5;    // per-sample tally width
  localparam int CIDX_W  = 2;    // configuration index width

  localparam logic [TALLY_W-1:0] TALLY_MAX = 5'd31;
  localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;
  localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_STUCK    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_WINDOW   = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd40;
  localparam logic [CFG_W-1:0] STUCK_RST    = 16'd700;
  localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd150;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] stuck_limit_ms;
    logic [CFG_W-1:0] pair_window_ms;
  } cfg_t;

  // per-lane step strobes
  typedef struct packed {
    logic inner_step;
    logic outer_step;
  } lane_ctrl_t;

endpackage

FILE: rtl/core/gpbtc_lane.sv
// ----------------------------------------------------------------------------
// gpbtc_lane
// one gate: debounced inner and outer beam tracking and crossing detection
// ----------------------------------------------------------------------------
module gpbtc_lane import gpbtc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  lane_ctrl_t       ctrl,
  input  cfg_t             cfg,
  input  logic [NOW_W-1:0] now,
  input  logic             en,
  input  logic [1:0]       pair,
  output logic             arr,
  output logic             dep
);

  logic               lvl_i_r, lvl_i_nxt, lvl_o_r, lvl_o_nxt;
  logic [NOW_W-1:0]   edge_i_r, edge_i_nxt, edge_o_r, edge_o_nxt;
  logic [NOW_W-1:0]   rel_i_r, rel_i_nxt, rel_o_r, rel_o_nxt;
  logic [DWELL_W-1:0] dw_i_r, dw_i_nxt, dw_o_r, dw_o_nxt;
  logic               arr_r, arr_nxt, dep_r, dep_nxt;

  logic               outer, inner;
  logic [NOW_W-1:0]   d_edge, d_rel;
  logic [DWELL_W-1:0] d_sat;
  logic               counted;

  assign outer = pair[0];
  assign inner = pair[1];

  always_comb begin
    lvl_i_nxt  = lvl_i_r;
    lvl_o_nxt  = lvl_o_r;
    edge_i_nxt = edge_i_r;
    edge_o_nxt = edge_o_r;
    rel_i_nxt  = rel_i_r;
    rel_o_nxt  = rel_o_r;
    dw_i_nxt   = dw_i_r;
    dw_o_nxt   = dw_o_r;
    arr_nxt    = arr_r;
    dep_nxt    = dep_r;

    // one shared time difference pair per step
    d_edge  = ctrl.outer_step ? (now - edge_o_r) : (now - edge_i_r);
    d_rel   = ctrl.outer_step ? (now - rel_i_r) : (now - rel_o_r);
    d_sat   = (d_edge[NOW_W-1:DWELL_W] != '0) ? '1 : d_edge[DWELL_W-1:0];
    counted = d_edge > {{(NOW_W-CFG_W){1'b0}}, cfg.debounce_ms};

    if (ctrl.inner_step) begin
      dep_nxt = 1'b0;
      if (en && (inner != lvl_i_r)) begin
        if (counted) begin
          if (!inner) begin
            rel_i_nxt = now;
            dw_i_nxt  = d_sat;
          end
          dep_nxt = !inner && !outer &&
                    (d_rel < {{(NOW_W-CFG_W){1'b0}}, cfg.pair_window_ms}) &&
                    ((dw_i_nxt < cfg.stuck_limit_ms) || (dw_o_r < cfg.stuck_limit_ms));
        end
        edge_i_nxt = now;
        lvl_i_nxt  = inner;
      end
    end

    // outer step runs in the cycle after the inner step and sees the inner beam's new state
    if (ctrl.outer_step) begin
      arr_nxt = 1'b0;
      if (en && (outer != lvl_o_r)) begin
        if (counted) begin
          if (!outer) begin
            rel_o_nxt = now;
            dw_o_nxt  = d_sat;
          end
          arr_nxt = !outer && !inner &&
                    (d_rel < {{(NOW_W-CFG_W){1'b0}}, cfg.pair_window_ms}) &&
                    ((dw_i_r < cfg.stuck_limit_ms) || (dw_o_nxt < cfg.stuck_limit_ms));
        end
        edge_o_nxt = now;
        lvl_o_nxt  = outer;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_i_r  <= 1'b0;
      lvl_o_r  <= 1'b0;
      edge_i_r <= '0;
      edge_o_r <= '0;
      rel_i_r  <= '0;
      rel_o_r  <= '0;
      dw_i_r   <= '0;
      dw_o_r   <= '0;
      arr_r    <= 1'b0;
      dep_r    <= 1'b0;
    end else begin
      lvl_i_r  <= lvl_i_nxt;
      lvl_o_r  <= lvl_o_nxt;
      edge_i_r <= edge_i_nxt;
      edge_o_r <= edge_o_nxt;
      rel_i_r  <= rel_i_nxt;
      rel_o_r  <= rel_o_nxt;
      dw_i_r   <= dw_i_nxt;
      dw_o_r   <= dw_o_nxt;
      arr_r    <= arr_nxt;
      dep_r    <= dep_nxt;
    end
  end

  assign arr = arr_r;
  assign dep = dep_r;

endmodule

FILE: rtl/core/gpbtc_merge.sv
// ----------------------------------------------------------------------------
// gpbtc_merge
// walks the lane flags in gate order, keeps the saturating net count
// ----------------------------------------------------------------------------
module gpbtc_merge import gpbtc_pkg::*; #(
  parameter int GATE_COUNT = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [GATE_COUNT-1:0]   arr_flags,
  input  logic [GATE_COUNT-1:0]   dep_flags,
  output logic signed [CNT_W-1:0] net_count,
  output logic [TALLY_W-1:0]      arr_cnt,
  output logic [TALLY_W-1:0]      dep_cnt,
  output logic                    done
);

  localparam int IDX_W = $clog2(GATE_COUNT);

  logic                    busy_r, busy_nxt, done_r, done_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic signed [CNT_W-1:0] net_r, net_nxt, net_mid;
  logic [TALLY_W-1:0]      arr_cnt_r, arr_cnt_nxt, dep_cnt_r, dep_cnt_nxt;
  logic                    a_flag, d_flag, last;

  assign a_flag = arr_flags[idx_r];
  assign d_flag = dep_flags[idx_r];
  assign last   = idx_r == IDX_W'(GATE_COUNT - 1);

  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    idx_nxt     = idx_r;
    net_nxt     = net_r;
    arr_cnt_nxt = arr_cnt_r;
    dep_cnt_nxt = dep_cnt_r;
    // departure (inner) goes before arrival (outer) within a gate
    net_mid     = (d_flag && (net_r != CNT_MIN)) ? net_r - 16'sd1 : net_r;
    if (start) begin
      busy_nxt    = 1'b1;
      idx_nxt     = '0;
      arr_cnt_nxt = '0;
      dep_cnt_nxt = '0;
    end else if (busy_r) begin
      net_nxt = (a_flag && (net_mid != CNT_MAX)) ? net_mid + 16'sd1 : net_mid;
      if (d_flag && (dep_cnt_r != TALLY_MAX)) dep_cnt_nxt = dep_cnt_r + 1'b1;
      if (a_flag && (arr_cnt_r != TALLY_MAX)) arr_cnt_nxt = arr_cnt_r + 1'b1;
      idx_nxt = idx_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
      idx_r     <= '0;
      net_r     <= '0;
      arr_cnt_r <= '0;
      dep_cnt_r <= '0;
    end else begin
      busy_r    <= busy_nxt;
      done_r    <= done_nxt;
      idx_r     <= idx_nxt;
      net_r     <= net_nxt;
      arr_cnt_r <= arr_cnt_nxt;
      dep_cnt_r <= dep_cnt_nxt;
    end
  end

  assign net_count = net_r;
  assign arr_cnt   = arr_cnt_r;
  assign dep_cnt   = dep_cnt_r;
  assign done      = done_r;

endmodule

FILE: rtl/core/gate_pair_bee_traffic_counter.sv
// ----------------------------------------------------------------------------
// gate_pair_bee_traffic_counter
// counts bee arrivals and departures over a row of two-beam gates
// ----------------------------------------------------------------------------
// a processed sample passes the inner step, the outer step, the in-order merge
//   walk over every gate and the output load; an ignored or baseline sample
//   goes straight to the output load; a new sample is taken only once back in
//   idle, after the last result is loaded; a held result stalls the input
// reset: rst_n synchronous active low; clears all gate state, counts, the output
//   valid and restores the configuration defaults (40, 700, 150)
// ----------------------------------------------------------------------------
module gate_pair_bee_traffic_counter import gpbtc_pkg::*; #(
  parameter int GATE_COUNT = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  // input items
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [79:0]       in_tdata,   // now_ms[31:0], sensor_bits[79:32]
  // result items
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // bee_count[15:0], sample_taken[16],
                                        // arrivals_now[21:17], departures_now[26:22]
  // configuration writes
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  // sensor word groups of four gates, eight bits each
  localparam int GRP_N = (GATE_COUNT + 3) / 4;
  localparam int PAD_W = 8 * GRP_N;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_INNER = 5'b00010,
    ST_OUTER = 5'b00100,
    ST_MERGE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  cfg_t              cfg_r, cfg_nxt;
  logic [NOW_W-1:0]  last_time_r, last_time_nxt;
  logic              base_pend_r, base_pend_nxt;
  logic [WORD_W-1:0] prev_word_r, prev_word_nxt;

  // sample held for the lanes
  logic [NOW_W-1:0]  now_r, now_nxt;
  logic [PAD_W-1:0]  word_r, word_nxt;
  logic [GRP_N-1:0]  chg_r, chg_nxt;
  logic              taken_r, taken_nxt;
  logic              walk_r, walk_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic signed [CNT_W-1:0] out_count_r, out_count_nxt;
  logic              out_taken_r, out_taken_nxt;
  logic [TALLY_W-1:0] out_arr_r, out_arr_nxt, out_dep_r, out_dep_nxt;

  logic [NOW_W-1:0]  in_now;
  logic [WORD_W-1:0] in_word;
  logic [63:0]       new_ext, old_ext;
  logic              in_fire, in_taken, out_free;

  lane_ctrl_t              lane_ctrl;
  logic [GATE_COUNT-1:0]   arr_flags, dep_flags;
  logic                    merge_start, merge_done;
  logic signed [CNT_W-1:0] net_count;
  logic [TALLY_W-1:0]      arr_cnt, dep_cnt;

  assign in_now   = in_tdata[NOW_W-1:0];
  assign in_word  = in_tdata[NOW_W +: WORD_W];
  assign in_tready = state_r == ST_IDLE;
  assign in_fire  = in_tvalid && in_tready;
  // plain unsigned compare, so time zero right after reset is ignored
  assign in_taken = in_now > last_time_r;
  // gates past the sensor word read as clear
  assign new_ext  = {{(64-WORD_W){1'b0}}, in_word};
  assign old_ext  = {{(64-WORD_W){1'b0}}, prev_word_r};
  assign out_free = !out_valid_r || out_tready;

  assign lane_ctrl.inner_step = state_r == ST_INNER;
  assign lane_ctrl.outer_step = state_r == ST_OUTER;
  assign merge_start          = state_r == ST_OUTER;

  // configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE: cfg_nxt.debounce_ms    = cfg_wdata;
        REG_STUCK:    cfg_nxt.stuck_limit_ms = cfg_wdata;
        REG_WINDOW:   cfg_nxt.pair_window_ms = cfg_wdata;
        default:      cfg_nxt = cfg_r;  // index beyond the register list
      endcase
    end
  end

  // sequencer and sample bookkeeping
  always_comb begin
    state_nxt     = state_r;
    last_time_nxt = last_time_r;
    base_pend_nxt = base_pend_r;
    prev_word_nxt = prev_word_r;
    now_nxt       = now_r;
    word_nxt      = word_r;
    chg_nxt       = chg_r;
    taken_nxt     = taken_r;
    walk_nxt      = walk_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_count_nxt = out_count_r;
    out_taken_nxt = out_taken_r;
    out_arr_nxt   = out_arr_r;
    out_dep_nxt   = out_dep_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          now_nxt   = in_now;
          word_nxt  = new_ext[PAD_W-1:0];
          taken_nxt = in_taken;
          walk_nxt  = in_taken && !base_pend_r;
          // only groups that changed since the previous taken sample enable their lanes
          for (int b = 0; b < GRP_N; b++) begin
            chg_nxt[b] = new_ext[8*b +: 8] != old_ext[8*b +: 8];
          end
          if (in_taken) begin
            last_time_nxt = in_now;
            base_pend_nxt = 1'b0;
            prev_word_nxt = in_word;
          end
          state_nxt = (in_taken && !base_pend_r) ? ST_INNER : ST_DONE;
        end
      end
      ST_INNER: state_nxt = ST_OUTER;
      ST_OUTER: state_nxt = ST_MERGE;
      ST_MERGE: begin
        if (merge_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = net_count;
          out_taken_nxt = taken_r;
          out_arr_nxt   = walk_r ? arr_cnt : '0;
          out_dep_nxt   = walk_r ? dep_cnt : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r                <= ST_IDLE;
      cfg_r.debounce_ms      <= DEBOUNCE_RST;
      cfg_r.stuck_limit_ms   <= STUCK_RST;
      cfg_r.pair_window_ms   <= WINDOW_RST;
      last_time_r            <= '0;
      base_pend_r            <= 1'b1;
      prev_word_r            <= '0;
      out_valid_r            <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      last_time_r <= last_time_nxt;
      base_pend_r <= base_pend_nxt;
      prev_word_r <= prev_word_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    word_r      <= word_nxt;
    chg_r       <= chg_nxt;
    taken_r     <= taken_nxt;
    walk_r      <= walk_nxt;
    out_count_r <= out_count_nxt;
    out_taken_r <= out_taken_nxt;
    out_arr_r   <= out_arr_nxt;
    out_dep_r   <= out_dep_nxt;
  end

  // one lane per gate, enabled by its group's change flag
  for (genvar g = 0; g < GATE_COUNT; g++) begin : g_lane
    gpbtc_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (lane_ctrl),
      .cfg   (cfg_r),
      .now   (now_r),
      .en    (chg_r[g / 4]),
      .pair  (word_r[2*g +: 2]),
      .arr   (arr_flags[g]),
      .dep   (dep_flags[g])
    );
  end

  // in-order merge of the lane results
  gpbtc_merge #(
    .GATE_COUNT (GATE_COUNT)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (merge_start),
    .arr_flags (arr_flags),
    .dep_flags (dep_flags),
    .net_count (net_count),
    .arr_cnt   (arr_cnt),
    .dep_cnt   (dep_cnt),
    .done      (merge_done)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_dep_r, out_arr_r, out_taken_r, out_count_r};

endmodule

FILE: sim/gpbtc_checker.sv
// ----------------------------------------------------------------------------
// gpbtc_checker
// watches the sample and tally channels of the bee traffic counter, keeps
// its own copy of the per-gate beam state, predicts every tally and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpbtc_checker import gpbtc_pkg::*; #(
  parameter int GATE_COUNT = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [79:0]       in_tdata,     // now_ms[31:0], sensor_bits[79:32]
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [31:0]       out_tdata,    // bee_count, sample_taken, arrivals, departures
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output int                error_count,
  output int                outstanding
);

  localparam int GROUPS = ((GATE_COUNT + 3) / 4 > 8) ? 8 : (GATE_COUNT + 3) / 4;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic signed [CNT_W-1:0] bee_count;
    logic                    taken;
    logic [TALLY_W-1:0]      arrivals;
    logic [TALLY_W-1:0]      departures;
  } sample_tally_t;

  cfg_t               cfg;
  logic [NOW_W-1:0]   last_ms;
  logic               baseline_due;
  logic [WORD_W-1:0]  prev_word;
  logic               inner_lvl   [GATE_COUNT];
  logic               outer_lvl   [GATE_COUNT];
  logic [NOW_W-1:0]   inner_edge  [GATE_COUNT];
  logic [NOW_W-1:0]   outer_edge  [GATE_COUNT];
  logic [NOW_W-1:0]   inner_rel   [GATE_COUNT];
  logic [NOW_W-1:0]   outer_rel   [GATE_COUNT];
  logic [DWELL_W-1:0] inner_dwell [GATE_COUNT];
  logic [DWELL_W-1:0] outer_dwell [GATE_COUNT];
  int                 net;
  sample_tally_t      pending_tallies [$];
  int                 errors;

  function automatic logic [DWELL_W-1:0] clip_dwell(logic [NOW_W-1:0] span);
    return (span > 32'h0000_ffff) ? 16'hffff : span[DWELL_W-1:0];
  endfunction

  // saturating net count plus the per-sample tally
  function automatic void credit(input int delta, inout logic [TALLY_W-1:0] tally);
    net += delta;
    if (net > int'(CNT_MAX)) net = int'(CNT_MAX);
    if (net < int'(CNT_MIN)) net = int'(CNT_MIN);
    if (tally < TALLY_MAX) tally++;
  endfunction

  function automatic sample_tally_t count_sample(logic [NOW_W-1:0] now,
                                                 logic [WORD_W-1:0] word);
    sample_tally_t      res;
    logic [63:0]        nw;
    logic [63:0]        ow;
    logic [7:0]         nb;
    logic [7:0]         ob;
    logic               inner;
    logic               outer;
    logic [TALLY_W-1:0] arr;
    logic [TALLY_W-1:0] dep;
    int                 g;
    res = '0;
    arr = '0;
    dep = '0;
    nw  = {16'b0, word};
    ow  = {16'b0, prev_word};
    if (now > last_ms) begin
      res.taken = 1'b1;
      last_ms   = now;
      if (baseline_due) begin
        baseline_due = 1'b0;
      end else begin
        for (int b = 0; b < GROUPS; b++) begin
          nb = nw[8*b +: 8];
          ob = ow[8*b +: 8];
          if (nb != ob) begin
            for (int s = 0; s < 4; s++) begin
              g = 4 * b + s;
              if (g < GATE_COUNT) begin
                outer = nb[2*s];
                inner = nb[2*s+1];
                // inner beam first, the outer check sees its new level
                if (inner != inner_lvl[g]) begin
                  if ((now - inner_edge[g]) > cfg.debounce_ms) begin
                    if (!inner) begin
                      inner_rel[g]   = now;
                      inner_dwell[g] = clip_dwell(now - inner_edge[g]);
                    end
                    if (!inner && !outer && (now - outer_rel[g]) < cfg.pair_window_ms &&
                        (inner_dwell[g] < cfg.stuck_limit_ms ||
                         outer_dwell[g] < cfg.stuck_limit_ms))
                      credit(-1, dep);
                  end
                  inner_edge[g] = now;
                  inner_lvl[g]  = inner;
                end
                if (outer != outer_lvl[g]) begin
                  if ((now - outer_edge[g]) > cfg.debounce_ms) begin
                    if (!outer) begin
                      outer_rel[g]   = now;
                      outer_dwell[g] = clip_dwell(now - outer_edge[g]);
                    end
                    if (!outer && !inner && (now - inner_rel[g]) < cfg.pair_window_ms &&
                        (inner_dwell[g] < cfg.stuck_limit_ms ||
                         outer_dwell[g] < cfg.stuck_limit_ms))
                      credit(1, arr);
                  end
                  outer_edge[g] = now;
                  outer_lvl[g]  = outer;
                end
              end
            end
          end
        end
      end
      prev_word = word;
    end
    res.bee_count  = net[CNT_W-1:0];
    res.arrivals   = arr;
    res.departures = dep;
    return res;
  endfunction

  task automatic report(string what, longint want, longint got);
    errors++;
    error_count = errors;
    if (errors <= MAX_PRINTED)
      $display("%0t mismatch: %s expected %0d got %0d", $time, what, want, got);
  endtask

  initial begin
    errors      = 0;
    error_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    sample_tally_t want;
    if (!rst_n) begin
      cfg          = '{DEBOUNCE_RST, STUCK_RST, WINDOW_RST};
      last_ms      = '0;
      baseline_due = 1'b1;
      prev_word    = '0;
      net          = 0;
      foreach (inner_lvl[g]) begin
        inner_lvl[g]   = 1'b0;
        outer_lvl[g]   = 1'b0;
        inner_edge[g]  = '0;
        outer_edge[g]  = '0;
        inner_rel[g]   = '0;
        outer_rel[g]   = '0;
        inner_dwell[g] = '0;
        outer_dwell[g] = '0;
      end
      pending_tallies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE: cfg.debounce_ms    = cfg_wdata;
          REG_STUCK:    cfg.stuck_limit_ms = cfg_wdata;
          REG_WINDOW:   cfg.pair_window_ms = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        pending_tallies.push_back(count_sample(in_tdata[31:0], in_tdata[79:32]));
      if (out_tvalid && out_tready) begin
        if (pending_tallies.size() == 0) begin
          report("result with no sample pending, raw tdata", -1, out_tdata);
        end else begin
          want = pending_tallies.pop_front();
          if ($signed(out_tdata[15:0]) != want.bee_count)
            report("bee_count", want.bee_count, $signed(out_tdata[15:0]));
          if (out_tdata[16] != want.taken)
            report("sample_taken", want.taken, out_tdata[16]);
          if (out_tdata[21:17] != want.arrivals)
            report("arrivals_now", want.arrivals, out_tdata[21:17]);
          if (out_tdata[26:22] != want.departures)
            report("departures_now", want.departures, out_tdata[26:22]);
        end
      end
    end
    outstanding = pending_tallies.size();
  end

endmodule

FILE: sim/gate_pair_bee_traffic_counter_tb.sv
// ----------------------------------------------------------------------------
// gate_pair_bee_traffic_counter_tb
// drives millisecond samples into the bee traffic counter: directed crossings
// first, then random bee traffic over several debounce / stuck / window
// settings, then runs that push the net count up and then down; a separate
// checker predicts and compares every tally item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gate_pair_bee_traffic_counter_tb;
  import gpbtc_pkg::*;

  localparam int GATES = 24;

  // beam patterns per gate, bit 0 outer, bit 1 inner
  // arrival: inner blocks first, outer clears last
  localparam logic [1:0] ARRIVE_SEQ [4] = '{2'b00, 2'b10, 2'b11, 2'b01};
  // departure: outer blocks first, inner clears last
  localparam logic [1:0] DEPART_SEQ [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

  localparam logic [WORD_W-1:0] ALL_OUTER = {GATES{2'b01}};
  localparam logic [WORD_W-1:0] ALL_INNER = {GATES{2'b10}};

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic [79:0]       in_tdata   = '0;
  logic              out_tready = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [CIDX_W-1:0] cfg_index  = REG_DEBOUNCE;
  logic [CFG_W-1:0]  cfg_wdata  = '0;
  logic              in_tready;
  logic              out_tvalid;
  logic [31:0]       out_tdata;

  int error_count;
  int outstanding;

  bit steady  = 1'b0;   // no gaps on either side
  bit rx_hold = 1'b0;   // ask the receiver for one long hold-off

  logic [NOW_W-1:0]  sim_ms;
  logic [WORD_W-1:0] beams;
  int                gate_step   [GATES];
  bit                gate_arrive [GATES];

  gate_pair_bee_traffic_counter #(
    .GATE_COUNT (GATES)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  gpbtc_checker #(
    .GATE_COUNT (GATES)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [WORD_W-1:0] with_pair(logic [WORD_W-1:0] word, int g,
                                                  logic [1:0] pair);
    word[2*g +: 2] = pair;
    return word;
  endfunction

  // offer one sample item and hold it until accepted; returns at a falling edge
  task automatic send_sample(logic [NOW_W-1:0] now, logic [WORD_W-1:0] word);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {word, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  // registers change only with the block idle and every tally item back
  task automatic write_settings(logic [CFG_W-1:0] debounce, logic [CFG_W-1:0] stuck,
                                logic [CFG_W-1:0] window);
    stop_sending();
    wait_drained();
    repeat (GATES + 8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_wdata <= debounce;
    @(negedge clk);
    cfg_index <= REG_STUCK;
    cfg_wdata <= stuck;
    @(negedge clk);
    cfg_index <= REG_WINDOW;
    cfg_wdata <= window;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random bee traffic: each gate walks through arrival or departure patterns,
  // with stray bit flips, garbage words and stale timestamps mixed in
  task automatic run_traffic(int n, bit with_pressure);
    logic [NOW_W-1:0]  now;
    logic [WORD_W-1:0] word;
    int                r;
    for (int i = 0; i < n; i++) begin
      // long receiver hold-off while items keep coming
      if (with_pressure && i == n / 3) rx_hold = 1'b1;
      // sender pause until every tally item is back
      if (with_pressure && i == 2 * n / 3) begin
        stop_sending();
        wait_drained();
      end
      word = '0;
      for (int g = 0; g < GATES; g++) begin
        if (gate_step[g] == 0) begin
          if ($urandom_range(0, 5) == 0) begin
            gate_step[g]   = 1;
            gate_arrive[g] = ($urandom_range(0, 1) == 1);
          end
        end else if ($urandom_range(0, 1) == 1) begin
          gate_step[g] = (gate_step[g] + 1) % 4;
        end
        word = with_pair(word, g, gate_arrive[g] ? ARRIVE_SEQ[gate_step[g]]
                                                 : DEPART_SEQ[gate_step[g]]);
      end
      r = $urandom_range(0, 99);
      if (r < 10) word ^= 48'h1 << $urandom_range(0, WORD_W - 1);
      else if (r < 13) word = WORD_W'({$urandom, $urandom});
      // step in ms: mostly near the debounce and window scale, rarely past dwell limit
      r = $urandom_range(0, 99);
      if (r < 5) begin
        now = sim_ms - $urandom_range(0, 500);   // stale or repeated time
      end else begin
        if (r < 78) sim_ms += $urandom_range(1, 60);
        else if (r < 93) sim_ms += $urandom_range(61, 300);
        else if (r < 98) sim_ms += $urandom_range(301, 2000);
        else sim_ms += $urandom_range(60000, 90000);
        now = sim_ms;
      end
      send_sample(now, word);
    end
  endtask

  // alternate a blocked pattern with all clear, 1 ms apart, one crossing per gate
  task automatic rail_run(int pairs, logic [WORD_W-1:0] blocked);
    for (int i = 0; i < pairs; i++) begin
      sim_ms += 1;
      send_sample(sim_ms, blocked);
      sim_ms += 1;
      send_sample(sim_ms, '0);
    end
  endtask

  // receiver: ready bursts with random gaps, a steady mode and one long hold
  initial begin
    int g;
    @(negedge clk);
    forever begin
      if (rx_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        rx_hold = 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
        @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        g = pick_gap();
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(negedge clk);
        end
      end
    end
  end

  // hard stop
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    foreach (gate_step[g]) begin
      gate_step[g]   = 0;
      gate_arrive[g] = 1'b0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed, reset settings (40 / 700 / 150) ----
    beams = '0;
    send_sample(32'd0, beams);              // time zero right after reset: ignored
    send_sample(32'd10, beams);             // baseline only
    send_sample(32'd10, '1);                // same time: ignored
    send_sample(32'd7, {24{2'b01}});        // earlier time: ignored
    // departure on gate 0: outer blocks, inner blocks, outer clears, inner clears
    beams = with_pair(beams, 0, 2'b01); send_sample(32'd100, beams);
    beams = with_pair(beams, 0, 2'b11); send_sample(32'd200, beams);
    beams = with_pair(beams, 0, 2'b10); send_sample(32'd260, beams);
    beams = with_pair(beams, 0, 2'b00); send_sample(32'd300, beams);
    // arrival on gate 5, second group
    beams = with_pair(beams, 5, 2'b10); send_sample(32'd400, beams);
    beams = with_pair(beams, 5, 2'b11); send_sample(32'd450, beams);
    beams = with_pair(beams, 5, 2'b01); send_sample(32'd500, beams);
    beams = with_pair(beams, 5, 2'b00); send_sample(32'd560, beams);
    // gate 9: outer pass sets a fresh release, then both clear in one sample,
    // which counts a departure and an arrival together
    beams = with_pair(beams, 9, 2'b01); send_sample(32'd900, beams);
    beams = with_pair(beams, 9, 2'b00); send_sample(32'd960, beams);
    beams = with_pair(beams, 9, 2'b11); send_sample(32'd1010, beams);
    beams = with_pair(beams, 9, 2'b00); send_sample(32'd1100, beams);
    // gate 12: flicker inside the debounce time, then a real edge
    beams = with_pair(beams, 12, 2'b01); send_sample(32'd1200, beams);
    beams = with_pair(beams, 12, 2'b00); send_sample(32'd1220, beams);
    beams = with_pair(beams, 12, 2'b01); send_sample(32'd1300, beams);
    // outer held past 16 bits of dwell, short inner dwell still counts
    beams = with_pair(beams, 12, 2'b11); send_sample(32'd71300, beams);
    beams = with_pair(beams, 12, 2'b10); send_sample(32'd71400, beams);
    beams = with_pair(beams, 12, 2'b00); send_sample(32'd71450, beams);
    // stuck bee on gate 16: both dwells past the stuck limit
    beams = with_pair(beams, 16, 2'b11); send_sample(32'd71500, beams);
    beams = with_pair(beams, 16, 2'b00); send_sample(32'd72500, beams);
    // every beam blocked, then every beam clear in one sample
    send_sample(32'd73000, '1);
    send_sample(32'd73100, '0);
    sim_ms = 32'd73100;

    // ---- random traffic over several settings ----
    write_settings(CFG_W'($urandom_range(0, 100)), CFG_W'($urandom_range(100, 2000)),
                   CFG_W'($urandom_range(20, 400)));
    run_traffic(200, 1'b0);
    write_settings('0, '1, '1);
    run_traffic(200, 1'b1);
    write_settings('1, '0, '0);
    run_traffic(100, 1'b0);
    write_settings(CFG_W'($urandom_range(0, 30)), CFG_W'($urandom_range(1, 65535)), '1);
    steady = 1'b1;
    run_traffic(150, 1'b0);
    steady = 1'b0;
    write_settings(CFG_W'($urandom_range(0, 60)), CFG_W'($urandom_range(200, 1000)),
                   CFG_W'($urandom_range(50, 300)));
    run_traffic(200, 1'b0);

    // ---- push the net count up with arrivals, then down with departures ----
    write_settings('0, '1, '1);
    steady = 1'b1;
    sim_ms += 1;
    send_sample(sim_ms, '1);                // fresh releases on both beams
    sim_ms += 1;
    send_sample(sim_ms, '0);
    rail_run(100, ALL_OUTER);               // arrivals only
    rail_run(100, ALL_INNER);               // departures only
    steady = 1'b0;

    // ---- timestamps at the top of the 32-bit range ----
    send_sample(32'h8000_0000, WORD_W'({$urandom, $urandom}));
    send_sample(32'haaaa_aaaa, WORD_W'({$urandom, $urandom}));
    send_sample(32'hffff_fffe, '1);
    send_sample(32'hffff_ffff, '0);
    send_sample(32'h5555_5555, WORD_W'({$urandom, $urandom}));   // ignored
    send_sample(32'hffff_ffff, '1);                              // ignored

    // drain and let the block settle
    stop_sending();
    wait_drained();
    repeat (GATES + 8) @(negedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: gate_pair_bee_traffic_counter.f
rtl/core/gpbtc_pkg.sv
rtl/core/gpbtc_lane.sv
rtl/core/gpbtc_merge.sv
rtl/core/gate_pair_bee_traffic_counter.sv
sim/gpbtc_checker.sv
sim/gate_pair_bee_traffic_counter_tb.sv
